// ===== rtl/aligned_first_fit_span_allocator_macros.svh =====
// Assertion macros used by the allocator source.
`ifndef ALIGNED_FIRST_FIT_SPAN_ALLOCATOR_MACROS_SVH
`define ALIGNED_FIRST_FIT_SPAN_ALLOCATOR_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define AFFSA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication whose consequence is checked in the cycle after the antecedent.
`define AFFSA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/affsa_pkg.sv =====
package affsa_pkg;

  localparam int FreeSlots = 16;
  localparam int AddrBits  = 27;
  localparam int IdxBits   = $clog2(FreeSlots);
  localparam int CntBits   = $clog2(FreeSlots + 1);
  localparam int OffBits   = 26;
  localparam int AlignBits = 13;
  localparam int CfgIdxBits = 1;
  localparam int CfgDataBits = 27;

  localparam logic [AddrBits-1:0] AddrLimit = {AddrBits{1'b1}};
  localparam logic [AddrBits:0]   OffsetMax = (AddrBits+1)'((64'd1 << OffBits) - 64'd1);

  localparam logic [AlignBits-1:0] AlignReset = AlignBits'(4);
  localparam logic [AddrBits-1:0]  ArenaReset = AddrBits'(64'd64 * 64'd1024 * 64'd1024);

  localparam logic [CfgIdxBits-1:0] RegAlign = 1'b0;
  localparam logic [CfgIdxBits-1:0] RegArena = 1'b1;

  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree  = 1'b1;

  typedef struct packed {
    logic [AddrBits-1:0] start;
    logic [AddrBits-1:0] len;
  } span_t;

  typedef struct packed {
    logic                op;
    logic [AddrBits-1:0] size;
    logic [OffBits-1:0]  sstart;
  } req_t;

  typedef struct packed {
    logic               granted;
    logic [OffBits-1:0] block_offset;
    logic               span_dropped;
  } rsp_t;

  // Control between the sequencer and the rounding unit.
  typedef struct packed {
    logic                start;
    logic [AddrBits-1:0] x;
    logic [AlignBits-1:0] a;
  } rnd_req_t;

  typedef struct packed {
    logic                done;
    logic [AddrBits:0]   q;  // rounded value, may exceed AddrBits
  } rnd_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD, ST_RND, ST_CHK, ST_SHRD, ST_SHWR, ST_TAIL, ST_HEAD,
    ST_BUMP, ST_BCHK, ST_OUT
  } state_t;

endpackage

// ===== rtl/affsa_if.sv =====
interface affsa_if #(
  parameter type T = logic
) (
  input logic clk
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/affsa_round.sv =====
// Rounds x up to a multiple of a (an a of zero counts as one) by restoring division, one quotient bit a cycle.
module affsa_round import affsa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  rnd_req_t req,
  output rnd_rsp_t rsp
);
  localparam int NB = AddrBits + 1;
  localparam int CB = $clog2(NB + 1);

  logic [NB-1:0]        num_r, num_nxt;
  logic [NB-1:0]        rem_r, rem_nxt;
  logic [NB-1:0]        quo_r, quo_nxt;
  logic [AlignBits-1:0] a_r, a_nxt;
  logic [CB-1:0]        cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [AddrBits:0]    res_r, res_nxt;
  logic [NB:0]          trial;
  logic [AddrBits+AlignBits:0] prod;

  always_comb begin
    num_nxt = num_r; rem_nxt = rem_r; quo_nxt = quo_r; a_nxt = a_r;
    cnt_nxt = cnt_r; busy_nxt = busy_r; done_nxt = 1'b0; res_nxt = res_r;
    trial = {rem_r, num_r[NB-1]} - {{(NB+1-AlignBits){1'b0}}, a_r};
    prod = {{AlignBits{1'b0}}, quo_r} * {{NB{1'b0}}, a_r};
    if (req.start) begin
      a_nxt = (req.a == '0) ? AlignBits'(1) : req.a;
      // x + a - 1, numerator of the ceiling division.
      num_nxt = {1'b0, req.x} + NB'(((req.a == '0) ? AlignBits'(1) : req.a) - 1'b1);
      rem_nxt = '0;
      quo_nxt = '0;
      cnt_nxt = CB'(NB);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        if (!trial[NB]) begin
          rem_nxt = trial[NB-1:0];
          quo_nxt = {quo_r[NB-2:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[NB-2:0], num_r[NB-1]};
          quo_nxt = {quo_r[NB-2:0], 1'b0};
        end
        num_nxt = {num_r[NB-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
      end else begin
        // Saturate: anything above the address range cannot fit anyway.
        res_nxt = (prod[AddrBits+AlignBits:AddrBits+1] != '0) ? {(AddrBits+1){1'b1}}
                                                             : prod[AddrBits:0];
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    num_r <= num_nxt; rem_r <= rem_nxt; quo_r <= quo_nxt; a_r <= a_nxt; res_r <= res_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.q = res_r;
endmodule

// ===== rtl/aligned_first_fit_span_allocator.sv =====
// Each request yields one response and only one request is in flight at a time.
// A free appends its span to the table if there is room. An allocate rounds the
// start of each free-table entry examined with the bit-serial rounding divider,
// shifts the later entries down on a hit, or else rounds the bump pointer.
// Synchronous active-low reset empties the table, zeroes the bump pointer and
// loads align_bytes 4 and arena_bytes 64 MiB.
module aligned_first_fit_span_allocator import affsa_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  affsa_if.sink                   in_req,
  affsa_if.source                 out_rsp,
  input  logic                    cfg_we,
  input  logic [CfgIdxBits-1:0]   cfg_idx,
  input  logic [CfgDataBits-1:0]  cfg_data
);
  `include "aligned_first_fit_span_allocator_macros.svh"

  span_t mem [FreeSlots];
  span_t rd_q;
  logic [IdxBits-1:0] rd_addr;
  logic               mem_we;
  logic [IdxBits-1:0] wr_addr;
  span_t              wr_data;

  state_t state_r, state_nxt;
  req_t   req_r;
  logic [AlignBits-1:0] align_r;
  logic [AddrBits-1:0]  arena_r;
  logic [CntBits-1:0]   cnt_r, cnt_nxt;
  logic [AddrBits-1:0]  bump_r, bump_nxt;
  logic [CntBits-1:0]   idx_r, idx_nxt;
  span_t                cur_r, cur_nxt;
  logic [AddrBits:0]    al_r, al_nxt;
  logic                 drop_r, drop_nxt;
  rsp_t                 rsp_r, rsp_nxt;
  logic                 ovalid_r, ovalid_nxt;
  logic                 cap_r;
  rnd_req_t             rreq;
  rnd_rsp_t             rrsp;
  logic [AlignBits-1:0] a_eff;
  logic [AddrBits+1:0]  blk_end, span_lim;
  logic                 fits;
  logic [AddrBits:0]    fe;
  logic [AddrBits-1:0]  fs;

  affsa_round u_round (.clk(clk), .rst_n(rst_n), .req(rreq), .rsp(rrsp));

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    rd_q <= mem[rd_addr];
  end

  assign a_eff = (align_r == '0) ? AlignBits'(1) : align_r;
  assign blk_end = {1'b0, al_r} + {2'b0, req_r.size};
  assign span_lim = {2'b0, cur_r.start} + {2'b0, cur_r.len};
  assign fits = (al_r <= OffsetMax) && (blk_end <= span_lim) &&
                (blk_end <= {2'b0, AddrLimit});
  assign fe = {1'b0, AddrBits'(req_r.sstart)} + {1'b0, req_r.size};
  assign fs = AddrBits'(req_r.sstart);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_req.valid) state_nxt = (in_req.data.op == OpFree) ? ST_OUT : ST_RD;
      ST_RD:   state_nxt = (idx_r < cnt_r) ? ST_RND : ST_BUMP;
      ST_RND:  if (rrsp.done) state_nxt = ST_CHK;
      ST_CHK:  state_nxt = fits ? ST_SHRD : ST_RD;
      ST_SHRD: state_nxt = (idx_r + 1'b1 < cnt_r) ? ST_SHWR : ST_TAIL;
      ST_SHWR: state_nxt = ST_SHRD;
      ST_TAIL: state_nxt = ST_HEAD;
      ST_HEAD: state_nxt = ST_OUT;
      ST_BUMP: state_nxt = ST_BCHK;
      ST_BCHK: if (rrsp.done) state_nxt = ST_OUT;
      ST_OUT:  if (ovalid_r && out_rsp.ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r; bump_nxt = bump_r; idx_nxt = idx_r; cur_nxt = cur_r;
    al_nxt = al_r; drop_nxt = drop_r; rsp_nxt = rsp_r; ovalid_nxt = ovalid_r;
    rd_addr = IdxBits'(idx_r); mem_we = 1'b0; wr_addr = IdxBits'(cnt_r); wr_data = '0;
    rreq = '0;
    if (out_rsp.ready) ovalid_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        idx_nxt = '0; drop_nxt = 1'b0; rsp_nxt = '0;
        rd_addr = '0;
      end
      ST_RD: begin
        rd_addr = IdxBits'(idx_r);
        if (!(idx_r < cnt_r)) begin
          rreq.start = 1'b1; rreq.x = bump_r; rreq.a = a_eff;
        end
      end
      ST_RND: begin
        al_nxt = rrsp.q;
      end
      ST_CHK: begin
        if (fits) begin
          rsp_nxt.granted = 1'b1;
          rsp_nxt.block_offset = al_r[OffBits-1:0];
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_SHRD: begin
        rd_addr = IdxBits'(idx_r + 1'b1);
      end
      ST_SHWR: begin
        mem_we = 1'b1; wr_addr = IdxBits'(idx_r); wr_data = rd_q;
        idx_nxt = idx_r + 1'b1;
      end
      ST_TAIL: begin
        cnt_nxt = cnt_r - 1'b1;
        if (span_lim != blk_end) begin
          mem_we = 1'b1; wr_addr = IdxBits'(cnt_r - 1'b1);
          wr_data.start = blk_end[AddrBits-1:0];
          wr_data.len = AddrBits'(span_lim - blk_end);
          cnt_nxt = cnt_r;
        end
      end
      ST_HEAD: begin
        if ((al_r - {1'b0, cur_r.start}) >= {{(AddrBits+1-AlignBits){1'b0}}, a_eff}) begin
          if (cnt_r < CntBits'(FreeSlots)) begin
            mem_we = 1'b1; wr_addr = IdxBits'(cnt_r);
            wr_data.start = cur_r.start;
            wr_data.len = AddrBits'(al_r - {1'b0, cur_r.start});
            cnt_nxt = cnt_r + 1'b1;
          end else begin
            rsp_nxt.span_dropped = 1'b1;
          end
        end
        ovalid_nxt = 1'b1;
      end
      ST_BUMP: begin
      end
      ST_BCHK: begin
        if (rrsp.done) begin
          ovalid_nxt = 1'b1;
          if (rrsp.q <= OffsetMax &&
              ({1'b0, rrsp.q} + {2'b0, req_r.size}) <= {2'b0, arena_r} &&
              ({1'b0, rrsp.q} + {2'b0, req_r.size}) <= {2'b0, AddrLimit}) begin
            bump_nxt = AddrBits'(rrsp.q + {1'b0, req_r.size});
            rsp_nxt.granted = 1'b1;
            rsp_nxt.block_offset = rrsp.q[OffBits-1:0];
          end
        end
      end
      ST_OUT: begin
        if (req_r.op == OpFree && !ovalid_r && rsp_r == '0 && !drop_r) begin
          drop_nxt = 1'b1;
          ovalid_nxt = 1'b1;
          if (cnt_r < CntBits'(FreeSlots)) begin
            mem_we = 1'b1; wr_addr = IdxBits'(cnt_r);
            wr_data.start = fs;
            wr_data.len = fe[AddrBits] ? AddrLimit - fs : AddrBits'(fe) - fs;
            cnt_nxt = cnt_r + 1'b1;
            rsp_nxt.granted = 1'b1;
          end else begin
            rsp_nxt.span_dropped = 1'b1;
          end
        end
      end
      default: ;
    endcase
    // The scanned entry arrives in the cycle after its read; its rounding starts in that cycle.
    if (cap_r) begin
      rreq.start = 1'b1; rreq.x = rd_q.start; rreq.a = a_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cap_r <= 1'b0;
    else cap_r <= (state_r == ST_RD) && (idx_r < cnt_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      align_r <= AlignReset;
      arena_r <= ArenaReset;
      cnt_r <= '0;
      bump_r <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      bump_r <= bump_nxt;
      ovalid_r <= ovalid_nxt;
      if (cfg_we && cfg_idx == RegAlign) align_r <= cfg_data[AlignBits-1:0];
      if (cfg_we && cfg_idx == RegArena) arena_r <= cfg_data[AddrBits-1:0];
    end
    idx_r <= idx_nxt; al_r <= al_nxt; drop_r <= drop_nxt; rsp_r <= rsp_nxt;
    cur_r <= cap_r ? rd_q : cur_nxt;
    if (state_r == ST_IDLE && in_req.valid) req_r <= in_req.data;
  end

  assign in_req.ready = (state_r == ST_IDLE);
  assign out_rsp.valid = ovalid_r;
  assign out_rsp.data = rsp_r;

  `AFFSA_ASSERT_IMP(a_cnt_range, 1'b1, cnt_r <= CntBits'(FreeSlots))
  `AFFSA_ASSERT_IMP(a_busy_no_accept, state_r != ST_IDLE, !in_req.ready)
  `AFFSA_ASSERT_NEXT(a_grant_drop_free, ovalid_r && req_r.op == OpFree,
                     rsp_r.granted != rsp_r.span_dropped || ovalid_r == 1'b0)
  `AFFSA_ASSERT_NEXT(a_rsp_stable, ovalid_r && !out_rsp.ready, ovalid_r && $stable(rsp_r))
endmodule

// ===== sim/aligned_first_fit_span_allocator_checker.sv =====
module aligned_first_fit_span_allocator_checker import affsa_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  req_t                   in_data,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  rsp_t                   out_data,
  input  logic                   cfg_we,
  input  logic [CfgIdxBits-1:0]  cfg_idx,
  input  logic [CfgDataBits-1:0] cfg_data,
  output int                     errors,
  output int                     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned Limit  = 64'(AddrLimit);
  localparam longint unsigned OffMax = 64'(OffsetMax);

  longint unsigned span_start_tbl [FreeSlots];
  longint unsigned span_len_tbl [FreeSlots];
  int              span_count;
  longint unsigned bump;
  longint unsigned align_reg;
  longint unsigned arena_reg;
  rsp_t            expected_rsps[$];

  initial begin
    errors = 0;
    pending = 0;
  end

  task automatic report(input string what, input longint unsigned got,
                        input longint unsigned want);
    $display("mismatch: %s got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic bit append_span(input longint unsigned s, input longint unsigned l);
    if (span_count >= FreeSlots) return 0;
    span_start_tbl[span_count] = s;
    span_len_tbl[span_count] = l;
    span_count++;
    return 1;
  endfunction

  function automatic rsp_t serve_request(input req_t r);
    rsp_t            res;
    longint unsigned a, sz, s, e, al, head, tail;
    bit              found, ok;
    res = '0;
    a = (align_reg == 0) ? 1 : align_reg;
    sz = 64'(r.size);
    if (r.op == OpFree) begin
      s = 64'(r.sstart);
      e = s + sz;
      if (e > Limit) e = Limit;
      if (append_span(s, e - s)) res.granted = 1'b1;
      else res.span_dropped = 1'b1;
      return res;
    end
    found = 0;
    for (int i = 0; i < span_count && !found; i++) begin
      s = span_start_tbl[i];
      e = s + span_len_tbl[i];
      al = (s + a - 1) / a * a;
      if (al > OffMax || al + sz > e || al + sz > Limit) continue;
      found = 1;
      head = al - s;
      tail = e - (al + sz);
      for (int k = i; k + 1 < span_count; k++) begin
        span_start_tbl[k] = span_start_tbl[k+1];
        span_len_tbl[k] = span_len_tbl[k+1];
      end
      span_count--;
      ok = 1;
      if (tail > 0) ok = append_span(al + sz, tail) && ok;
      if (head >= a) ok = append_span(s, head) && ok;
      res.granted = 1'b1;
      res.block_offset = al[OffBits-1:0];
      res.span_dropped = !ok;
    end
    if (found) return res;
    al = (bump + a - 1) / a * a;
    if (al > OffMax || al + sz > arena_reg || al + sz > Limit) return res;
    bump = al + sz;
    res.granted = 1'b1;
    res.block_offset = al[OffBits-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (!rst_n) begin
      span_count = 0;
      bump = 0;
      align_reg = 64'(AlignReset);
      arena_reg = 64'(ArenaReset);
      expected_rsps.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_idx == RegAlign) align_reg = 64'(cfg_data[AlignBits-1:0]);
        else arena_reg = 64'(cfg_data);
      end
      if (in_valid && in_ready)
        expected_rsps.insert(expected_rsps.size(), serve_request(in_data));
      if (out_valid && out_ready) begin
        if (expected_rsps.size() == 0) begin
          report("unexpected response", 1, 0);
        end else begin
          want = expected_rsps[0];
          expected_rsps.delete(0);
          if (out_data.granted !== want.granted)
            report("granted", out_data.granted, want.granted);
          if (out_data.block_offset !== want.block_offset)
            report("block_offset", out_data.block_offset, want.block_offset);
          if (out_data.span_dropped !== want.span_dropped)
            report("span_dropped", out_data.span_dropped, want.span_dropped);
        end
      end
    end
    pending = expected_rsps.size();
  end
endmodule

// ===== sim/aligned_first_fit_span_allocator_test.sv =====
module aligned_first_fit_span_allocator_test import affsa_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 20000;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CfgIdxBits-1:0]  cfg_idx;
  logic [CfgDataBits-1:0] cfg_data;
  int                     errors;
  int                     pending;
  bit                     idling_on;
  int                     stall_left;
  int                     quiet_cycles;
  int                     sent;
  int                     settings_used;

  affsa_if #(.T(req_t)) in_req (clk);
  affsa_if #(.T(rsp_t)) out_rsp (clk);

  aligned_first_fit_span_allocator dut (
    .clk(clk), .rst_n(rst_n), .in_req(in_req), .out_rsp(out_rsp),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  aligned_first_fit_span_allocator_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_req.valid), .in_ready(in_req.ready), .in_data(in_req.data),
    .out_valid(out_rsp.valid), .out_ready(out_rsp.ready), .out_data(out_rsp.data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Response side backpressure in random bursts.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_rsp.ready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 9);
      out_rsp.ready <= 1'b0;
    end else begin
      out_rsp.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_req.valid && in_req.ready) || (out_rsp.valid && out_rsp.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("timeout with %0d responses outstanding", pending);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Valid stays high between back-to-back requests; it only drops for a gap.
  task automatic send(input logic op, input logic [AddrBits-1:0] size,
                      input logic [OffBits-1:0] sstart);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_req.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_req.valid <= 1'b1;
    in_req.data <= '{op: op, size: size, sstart: sstart};
    do @(posedge clk); while (!in_req.ready);
    sent++;
  endtask

  task automatic drain();
    in_req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input logic [CfgDataBits-1:0] d);
    drain();
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic random_request(input int arena_span);
    logic [AddrBits-1:0] size;
    logic [OffBits-1:0]  st;
    case ($urandom_range(0, 9))
      0:       size = AddrBits'($urandom());
      1:       size = '0;
      default: size = AddrBits'($urandom_range(1, 600));
    endcase
    if ($urandom_range(0, 9) == 0) st = OffBits'($urandom());
    else st = OffBits'($urandom_range(0, arena_span));
    send(1'($urandom_range(0, 1)), size, st);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = RegAlign;
    cfg_data = '0;
    in_req.valid = 1'b0;
    in_req.data = '0;
    out_rsp.ready = 1'b0;
    idling_on = 1'b1;
    stall_left = 0;
    quiet_cycles = 0;
    sent = 0;
    settings_used = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: bump path, zero size, table hits with discarded heads.
    send(OpAlloc, 1, 0);
    send(OpAlloc, 0, 0);
    send(OpFree, 50, 101);
    send(OpAlloc, 10, 0);
    send(OpFree, 0, 7);
    send(OpAlloc, 0, 0);
    // Returned span beyond the address range saturates.
    send(OpFree, {AddrBits{1'b1}}, {OffBits{1'b1}});
    send(OpAlloc, {AddrBits{1'b1}}, 0);
    // Fill the table so frees get dropped.
    for (int i = 0; i < 18; i++) send(OpFree, 40, OffBits'(1000 + i * 64));
    send(OpAlloc, 8, 0);
    send(OpAlloc, 8, 0);
    drain();

    write_reg(RegAlign, 0);
    write_reg(RegArena, 1);
    send(OpAlloc, 1, 0);
    send(OpAlloc, 2, 0);
    write_reg(RegAlign, 3);
    write_reg(RegArena, {CfgDataBits{1'b1}});
    send(OpAlloc, 5, 0);

    for (int ph = 0; ph < 8; ph++) begin
      int span_hi;
      case (ph)
        0: begin write_reg(RegAlign, 4096); write_reg(RegArena, 1); end
        1: begin write_reg(RegAlign, 8191); write_reg(RegArena, 67108864); end
        2: begin write_reg(RegAlign, 1); write_reg(RegArena, 5000); end
        7: begin write_reg(RegAlign, 4); write_reg(RegArena, 67108864); end
        default: begin
          write_reg(RegAlign, CfgDataBits'($urandom_range(1, 64)));
          write_reg(RegArena, CfgDataBits'($urandom_range(1, 200000)));
        end
      endcase
      idling_on = (ph != 7);
      span_hi = (ph < 2) ? 100000 : 8000;
      for (int n = 0; n < 210; n++) begin
        if (ph == 3 && n == 100) drain();
        random_request(span_hi);
      end
    end
    drain();

    $display("Sent %0d requests over %0d register writes: table hits, bump growth,",
             sent, settings_used);
    $display("full-table drops, saturated frees and exhausted arenas, with backpressure.");
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
